>>> design/u16u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and constants for the UTF-16LE to UTF-8 transcoder
// Holds the code point entry that the front passes to the back and the
// byte encoding function used by the back serializer.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int CpWidth  = 21;
  localparam int LenWidth = 2;
  localparam int IdxWidth = 2;

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;

  localparam logic [4:0]  SurrogateTag = 5'b11011;
  localparam logic [10:0] SuppOffset   = 11'h040;

  typedef struct packed {
    logic [CpWidth-1:0]  cp;
    logic [LenWidth-1:0] len;
  } cp_entry_t;

  function automatic logic [7:0] encode_byte(input logic [CpWidth-1:0] cp,
                                              input logic [LenWidth-1:0] len,
                                              input logic [IdxWidth-1:0] idx);
    logic [7:0] b;
    b = {1'b0, cp[6:0]};
    case (len)
      2'd0: begin
        b = {1'b0, cp[6:0]};
      end
      2'd1: begin
        case (idx)
          2'd0:    b = Lead2 | {3'b000, cp[10:6]};
          default: b = Cont | {2'b00, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = Lead3 | {4'b0000, cp[15:12]};
          2'd1:    b = Cont | {2'b00, cp[11:6]};
          default: b = Cont | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = Lead4 | {5'b00000, cp[20:18]};
          2'd1:    b = Cont | {2'b00, cp[17:12]};
          2'd2:    b = Cont | {2'b00, cp[11:6]};
          default: b = Cont | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> design/utf16le_to_utf8_transcoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder: UTF-16LE byte stream to UTF-8 byte stream
//
//   Channel  Direction  Signals                      Meaning
//   in       sink       in_valid/in_ready, data_byte  raw UTF-16LE byte
//   out      source     out_valid/out_ready,          UTF-8 byte, last marks
//                       utf8_byte, last               the end of a code point
//
// The front takes one input byte per cycle while the code point queue has room.
// The back serializer sends one UTF-8 byte per cycle while out_ready is high;
// a code point gives one to four bytes, two input bytes of BMP up to three.
// A code point is registered in the queue, then in the back's entry register.
// Reset empties the queue and clears pairing and surrogate state.
// Either side may stall; the queue lets the front keep accepting meanwhile.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [7:0]      utf8_byte,
  output logic            last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  logic                 q_full;
  logic                 push;
  u16u8_pkg::cp_entry_t push_entry;
  logic                 pop;
  logic                 q_valid;
  u16u8_pkg::cp_entry_t q_entry;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .utf8_byte (utf8_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

>>> design/u16u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front: byte pairing and surrogate handling
// Pairs bytes into code units, joins surrogate pairs, drops lone surrogates
// plus the unit after a lone high one; pushes code points and UTF-8 lengths.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 q_full,
  output logic                      push,
  output u16u8_pkg::cp_entry_t      push_entry
);

  logic [7:0]  pending_low_byte;
  logic        have_low_byte;
  logic [9:0]  held_high_bits;
  logic        have_high_surrogate;

  logic [15:0] unit;
  logic        is_sur;
  logic        is_hi;
  logic        is_lo;
  logic        emit;
  logic        accept;
  logic [10:0] plane;
  logic [u16u8_pkg::CpWidth-1:0] cp;

  assign unit   = {data_byte, pending_low_byte};
  assign is_sur = (unit[15:11] == u16u8_pkg::SurrogateTag);
  assign is_hi  = is_sur & ~unit[10];
  assign is_lo  = is_sur & unit[10];
  assign emit   = have_high_surrogate ? is_lo : ~is_sur;
  assign plane  = {1'b0, held_high_bits} + u16u8_pkg::SuppOffset;
  assign cp     = have_high_surrogate ? {plane, unit[9:0]} : {5'b00000, unit};

  assign in_ready = ~have_low_byte | ~q_full;
  assign accept   = in_valid & in_ready;
  assign push     = accept & have_low_byte & emit;

  always_comb begin
    push_entry.cp = cp;
    if (cp[20:16] != 5'd0) begin
      push_entry.len = 2'd3;
    end else if (cp[15:11] != 5'd0) begin
      push_entry.len = 2'd2;
    end else if (cp[10:7] != 4'd0) begin
      push_entry.len = 2'd1;
    end else begin
      push_entry.len = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_low_byte       <= 1'b0;
      have_high_surrogate <= 1'b0;
    end else if (accept) begin
      if (!have_low_byte) begin
        have_low_byte <= 1'b1;
      end else begin
        have_low_byte <= 1'b0;
        if (have_high_surrogate) begin
          have_high_surrogate <= 1'b0;
        end else if (is_hi) begin
          have_high_surrogate <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !have_low_byte) begin
      pending_low_byte <= data_byte;
    end
    if (accept && have_low_byte && !have_high_surrogate && is_hi) begin
      held_high_bits <= unit[9:0];
    end
  end

endmodule
`default_nettype wire

>>> design/u16u8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue: code point queue
// A small FIFO of code point entries between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire u16u8_pkg::cp_entry_t push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      pop_valid,
  output u16u8_pkg::cp_entry_t      pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16u8_pkg::cp_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/u16u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back: UTF-8 byte serializer
// Holds one code point and emits its UTF-8 bytes one beat at a time.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire u16u8_pkg::cp_entry_t q_entry,
  output logic                      pop,
  output logic [7:0]                utf8_byte,
  output logic                      last,
  output logic                      out_valid,
  input  wire logic                 out_ready
);

  u16u8_pkg::cp_entry_t           cur;
  logic                           cur_valid;
  logic [u16u8_pkg::IdxWidth-1:0] idx;
  logic                           beat;

  assign out_valid = cur_valid;
  assign utf8_byte = u16u8_pkg::encode_byte(cur.cp, cur.len, idx);
  assign last      = (idx == cur.len);
  assign beat      = cur_valid & out_ready;
  assign pop       = q_valid & (~cur_valid | (beat & last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (beat) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
  end

endmodule
`default_nettype wire

>>> design/u16u8_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_checker: port checks for the transcoder
// Watches the output: idle after reset, held when stalled, UTF-8 byte rules.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] utf8_byte,
  input wire logic       last,
  input wire logic       out_valid,
  input wire logic       out_ready
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(utf8_byte) && $stable(last)))
    else $error("Stalled output beat changed.");

  a_ascii_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !utf8_byte[7]) |-> last)
    else $error("Single-byte code point not marked last.");

  a_lead_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && utf8_byte[7:6] == 2'b11) |-> !last)
    else $error("Lead byte marked last.");

  a_no_overlong: assert property (@(posedge clk) disable iff (rst)
    (out_valid && utf8_byte[7:5] == 3'b110) |-> (utf8_byte[4:1] != 4'd0))
    else $error("Overlong two-byte lead.");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (.*);
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf16le_to_utf8_transcoder
// Feeds a little-endian UTF-16 byte stream through the valid/ready input,
// tracks pairing and surrogate state in a predictor class, and compares every
// UTF-8 output beat, byte and last flag, against the predicted sequence. Both
// channels idle at random, with one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam int IdleLimit  = 2000;
  localparam int StallBeats = 300;
  localparam int HoldAt     = 120;
  localparam int DrainAt    = 240;
  localparam int ByteTarget = 360;

  class utf8_tracker;
    typedef struct packed {
      logic [7:0] value;
      logic       last;
    } utf8_beat_t;

    logic [7:0] low_half;
    bit         low_valid;
    logic [9:0] lead_bits;
    bit         lead_valid;
    utf8_beat_t awaited[$];
    int         errors;
    int         beats_checked;
    int         code_points;
    int         units_dropped;

    function new();
      low_half      = '0;
      low_valid     = 0;
      lead_bits     = '0;
      lead_valid    = 0;
      errors        = 0;
      beats_checked = 0;
      code_points   = 0;
      units_dropped = 0;
    endfunction

    function void push_beat(logic [7:0] value, logic last);
      utf8_beat_t b;
      b.value = value;
      b.last  = last;
      awaited.push_back(b);
    endfunction

    function void emit_code_point(logic [20:0] cp);
      code_points++;
      if (cp <= 21'h7F) begin
        push_beat(cp[7:0], 1'b1);
      end else if (cp <= 21'h7FF) begin
        push_beat(8'hC0 | {3'b000, cp[10:6]}, 1'b0);
        push_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1);
      end else if (cp <= 21'hFFFF) begin
        push_beat(8'hE0 | {4'b0000, cp[15:12]}, 1'b0);
        push_beat(8'h80 | {2'b00, cp[11:6]}, 1'b0);
        push_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1);
      end else begin
        push_beat(8'hF0 | {5'b00000, cp[20:18]}, 1'b0);
        push_beat(8'h80 | {2'b00, cp[17:12]}, 1'b0);
        push_beat(8'h80 | {2'b00, cp[11:6]}, 1'b0);
        push_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1);
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] unit;
      logic [20:0] cp;
      if (!low_valid) begin
        low_half  = b;
        low_valid = 1;
        return;
      end
      unit = {b, low_half};
      low_valid = 0;
      if (lead_valid) begin
        lead_valid = 0;
        if (unit >= LowFirst && unit <= LowLast) begin
          cp = 21'h10000 + {1'b0, lead_bits, unit[9:0]};
          emit_code_point(cp);
        end else begin
          units_dropped += 2;
        end
      end else if (unit >= HighFirst && unit <= HighLast) begin
        lead_bits  = unit[9:0];
        lead_valid = 1;
      end else if (unit >= LowFirst && unit <= LowLast) begin
        units_dropped++;
      end else begin
        emit_code_point({5'b00000, unit});
      end
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      utf8_beat_t want;
      if (awaited.size() == 0) begin
        $error("unexpected output beat: utf8_byte %h, last %b", value, last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      beats_checked++;
      if (value !== want.value) begin
        $error("utf8_byte mismatch: expected %h, actual %h", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic [7:0] data_byte;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] utf8_byte;
  logic       last;
  logic       out_valid;
  logic       out_ready;

  utf8_tracker trk;
  logic [7:0]  stream[$];
  int          burst_left;
  int          bytes_sent;
  bit          hold_request;

  utf16le_to_utf8_transcoder u_top (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .utf8_byte (utf8_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_unit(logic [15:0] unit);
    stream.push_back(unit[7:0]);
    stream.push_back(unit[15:8]);
  endfunction

  function automatic void add_random_units();
    int          pick;
    logic [15:0] unit;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_unit(16'($urandom_range(0, 16'h7F)));
    end else if (pick < 35) begin
      add_unit(16'($urandom_range(16'h80, 16'h7FF)));
    end else if (pick < 55) begin
      if ($urandom_range(0, 1) == 0) begin
        add_unit(16'($urandom_range(16'h800, 16'hD7FF)));
      end else begin
        add_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
    end else if (pick < 75) begin
      add_unit(HighFirst | 16'($urandom_range(0, 16'h3FF)));
      add_unit(LowFirst | 16'($urandom_range(0, 16'h3FF)));
    end else if (pick < 83) begin
      add_unit(HighFirst | 16'($urandom_range(0, 16'h3FF)));
      unit = 16'($urandom_range(0, 16'hFFFF));
      if (unit >= LowFirst && unit <= LowLast) begin
        unit = unit ^ 16'h0400;
      end
      add_unit(unit);
    end else if (pick < 90) begin
      add_unit(LowFirst | 16'($urandom_range(0, 16'h3FF)));
    end else begin
      add_unit(16'($urandom_range(0, 16'hFFFF)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = $urandom_range(30, 60);
      end else begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    trk.take_byte(b);
    bytes_sent++;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    data_byte    = 8'h00;
    burst_left   = 0;
    bytes_sent   = 0;
    hold_request = 0;
    trk = new();

    add_unit(16'h0000);
    add_unit(16'h007F);
    add_unit(16'h0080);
    add_unit(16'h07FF);
    add_unit(16'h0800);
    add_unit(16'hFFFF);
    add_unit(HighFirst);
    add_unit(LowFirst);
    add_unit(HighLast);
    add_unit(LowLast);
    add_unit(16'hD834);
    add_unit(16'h0041);
    add_unit(16'hDA00);
    add_unit(16'hDB00);
    add_unit(16'hDC00);
    while (stream.size() < ByteTarget) begin
      add_random_units();
    end
    stream.push_back(8'($urandom_range(0, 255)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stream[i]) begin
      if (i == HoldAt) begin
        hold_request = 1;
      end
      if (i == DrainAt) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (trk.outstanding() != 0) @(posedge clk);
      end
      send_byte(stream[i]);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (trk.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d bytes; %0d code points predicted, %0d units dropped.",
             bytes_sent, trk.code_points, trk.units_dropped);
    $display("Checked %0d UTF-8 beats under random gaps, stalls and a full queue.",
             trk.beats_checked);
    if (trk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int  mode;
    int  mode_left;
    int  phase;
    bit  hold_done;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    hold_done = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1;
        out_ready <= 1'b0;
        repeat (StallBeats) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 96);
      end
      mode_left--;
      phase++;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          out_ready <= (phase % 3 == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      trk.check_byte(utf8_byte, last);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (rst) @(posedge clk);
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $error("no beat accepted for %0d cycles", IdleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
